FILE: design/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg: shared types and codes for the keyed slot table
// Field widths, action and status codes, controller states, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int ACTION_W = 2;
  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 6;
  localparam int LIVE_W   = 7;

  localparam logic [ACTION_W-1:0] ACT_SET = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_GET = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DEL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADKEY = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_APPLY,
    S_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;  // zero one key slot, advance the sweep
    logic load;      // capture the request, restart the scan
    logic scan_rd;   // read one key slot, advance the scan
    logic apply;     // write back the table, start the value read
    logic respond;   // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;   // sweep is on the last slot
    logic scan_last;  // scan is on the last slot
    logic special;    // offered request needs no scan
    logic out_busy;   // result register holds an untaken result
  } sts_t;

endpackage

FILE: design/keyed_slot_table.sv
// ----------------------------------------------------------------------------
// keyed_slot_table: fixed-size key/value table with linear search
// Maps nonzero 64-bit keys to 64-bit values in SLOTS slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one action: set, lookup or
//   delete, with a key and, for set, a value. Each transfer gives exactly
//   one result transfer on the output channel (out_valid/out_ready) with a
//   status, the slot touched, the looked-up value and the live count.
//   A request makes one pass over the key memory, one slot per cycle,
//   tracking a key match and the lowest free slot together. It then writes
//   back and responds. A request with key zero or action three skips the
//   pass. One request is in flight at a time: a new request is accepted
//   only after the result of the last one is loaded into the output
//   register, and the pass is paced by the single read port of the key
//   memory.
//   After reset the block sweeps the key memory to zero, one slot per
//   cycle; in_ready stays low meanwhile.
//   A stalled receiver holds the result in the output register; the block
//   takes the next request anyway and parks its result until the register
//   frees up.
// ----------------------------------------------------------------------------
module keyed_slot_table #(
  parameter int SLOTS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [kst_pkg::ACTION_W-1:0]   in_action,
  input  logic [kst_pkg::KEY_W-1:0]      in_key,
  input  logic [kst_pkg::VALUE_W-1:0]    in_write_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [kst_pkg::STATUS_W-1:0]   out_status,
  output logic [kst_pkg::SLOT_W-1:0]     out_slot_index,
  output logic [kst_pkg::VALUE_W-1:0]    out_read_value,
  output logic [kst_pkg::LIVE_W-1:0]     out_live_count
);
  import kst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: clearing sweep, then scan and write back per request
  kst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Memories, trackers, live count and result register
  kst_dp #(.SLOTS(SLOTS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (in_action),
    .in_key         (in_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot_index (out_slot_index),
    .out_read_value (out_read_value),
    .out_live_count (out_live_count)
  );

endmodule

FILE: design/kst_ram.sv
// ----------------------------------------------------------------------------
// kst_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module kst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/kst_ctrl.sv
// ----------------------------------------------------------------------------
// kst_ctrl: sequencer for the keyed slot table
// Sweeps the key memory after reset, then runs accept, scan, write back
// and respond for one request at a time; a special request skips to respond.
// ----------------------------------------------------------------------------
module kst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  kst_pkg::sts_t sts,
  output kst_pkg::cmd_t cmd
);
  import kst_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) state_nxt = sts.special ? S_RESP : S_SCAN;
      end
      S_SCAN:  if (sts.scan_last) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_RESP;
      S_RESP:  if (!sts.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN:  cmd.scan_rd = 1'b1;
      S_DRAIN: ;
      S_APPLY: cmd.apply = 1'b1;
      S_RESP:  cmd.respond = !sts.out_busy;
      default: ;
    endcase
  end

  // Write back comes only after the last key compare
  a_apply_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_APPLY |-> $past(state_r) == S_DRAIN)
    else $error("write back without a finished scan");

endmodule

FILE: design/kst_dp.sv
// ----------------------------------------------------------------------------
// kst_dp: datapath of the keyed slot table
// Key and value memories, scan counter, match and free-slot trackers,
// live count and the result register.
// ----------------------------------------------------------------------------
module kst_dp #(
  parameter int SLOTS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  kst_pkg::cmd_t                  cmd,
  output kst_pkg::sts_t                  sts,
  input  logic [kst_pkg::ACTION_W-1:0]   in_action,
  input  logic [kst_pkg::KEY_W-1:0]      in_key,
  input  logic [kst_pkg::VALUE_W-1:0]    in_write_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [kst_pkg::STATUS_W-1:0]   out_status,
  output logic [kst_pkg::SLOT_W-1:0]     out_slot_index,
  output logic [kst_pkg::VALUE_W-1:0]    out_read_value,
  output logic [kst_pkg::LIVE_W-1:0]     out_live_count
);
  import kst_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic [ACTION_W-1:0] action_r;
  logic [KEY_W-1:0]    key_r;
  logic [VALUE_W-1:0]  wval_r;
  logic [IW-1:0]       cnt_r;
  logic                rd_vld_r;
  logic                hit_r;
  logic [IW-1:0]       hit_at_r;
  logic                free_r;
  logic [IW-1:0]       free_at_r;
  logic [CW-1:0]       count_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [VALUE_W-1:0]  rval_r;
  logic [LIVE_W-1:0]   live_r;

  logic                key_wr_en;
  logic [IW-1:0]       key_wr_addr;
  logic [KEY_W-1:0]    key_wr_data;
  logic [KEY_W-1:0]    key_rd_data;
  logic                val_wr_en;
  logic [IW-1:0]       val_wr_addr;
  logic                val_rd_en;
  logic [VALUE_W-1:0]  val_rd_data;

  logic                claim;
  logic                drop;
  logic [STATUS_W-1:0] status_nxt;
  logic [IW-1:0]       slot_nxt;
  logic [VALUE_W-1:0]  rval_nxt;

  assign claim = cmd.apply && action_r == ACT_SET && !hit_r && free_r;
  assign drop  = cmd.apply && action_r == ACT_DEL && hit_r;

  always_comb begin
    key_wr_en   = 1'b0;
    key_wr_addr = cnt_r;
    key_wr_data = '0;
    if (cmd.clr_step) begin
      key_wr_en = 1'b1;
    end else if (claim) begin
      key_wr_en   = 1'b1;
      key_wr_addr = free_at_r;
      key_wr_data = key_r;
    end else if (drop) begin
      key_wr_en   = 1'b1;
      key_wr_addr = hit_at_r;
    end
  end

  assign val_wr_en   = cmd.apply && action_r == ACT_SET && (hit_r || free_r);
  assign val_wr_addr = hit_r ? hit_at_r : free_at_r;
  assign val_rd_en   = cmd.apply && action_r == ACT_GET && hit_r;

  kst_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (key_wr_addr),
    .wr_data (key_wr_data),
    .rd_en   (cmd.scan_rd),
    .rd_addr (cnt_r),
    .rd_data (key_rd_data)
  );

  kst_ram #(.WIDTH(VALUE_W), .DEPTH(SLOTS)) u_val_ram (
    .clk     (clk),
    .wr_en   (val_wr_en),
    .wr_addr (val_wr_addr),
    .wr_data (wval_r),
    .rd_en   (val_rd_en),
    .rd_addr (hit_at_r),
    .rd_data (val_rd_data)
  );

  // Request capture, scan and tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
      count_r  <= '0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.load) begin
        cnt_r  <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (cmd.clr_step || cmd.scan_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (rd_vld_r) begin
        if (!hit_r && key_rd_data == key_r) begin
          hit_r    <= 1'b1;
          hit_at_r <= cnt_r - 1'b1;
        end
        if (!free_r && key_rd_data == '0) begin
          free_r    <= 1'b1;
          free_at_r <= cnt_r - 1'b1;
        end
      end
      if (claim) begin
        count_r <= count_r + 1'b1;
      end else if (drop && count_r != '0) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      key_r    <= in_key;
      wval_r   <= in_write_value;
    end
  end

  // Result selection
  always_comb begin
    status_nxt = ST_MISS;
    slot_nxt   = '0;
    rval_nxt   = '0;
    if (action_r != ACT_SET && action_r != ACT_GET && action_r != ACT_DEL) begin
      status_nxt = ST_MISS;
    end else if (key_r == '0) begin
      status_nxt = ST_BADKEY;
    end else if (hit_r) begin
      status_nxt = ST_OK;
      slot_nxt   = hit_at_r;
      if (action_r == ACT_GET) rval_nxt = val_rd_data;
    end else if (action_r == ACT_SET) begin
      status_nxt = free_r ? ST_OK : ST_FULL;
      slot_nxt   = free_r ? free_at_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.respond) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      status_r <= status_nxt;
      slot_r   <= SLOT_W'(slot_nxt);
      rval_r   <= rval_nxt;
      live_r   <= LIVE_W'(count_r);
    end
  end

  assign sts.clr_last  = cnt_r == IW'(SLOTS - 1);
  assign sts.scan_last = cnt_r == IW'(SLOTS - 1);
  assign sts.special   = (in_action != ACT_SET && in_action != ACT_GET &&
                          in_action != ACT_DEL) || in_key == '0;
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_slot_index = slot_r;
  assign out_read_value = rval_r;
  assign out_live_count = live_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SLOTS))
    else $error("live count above table size");

  a_claim_counts: assert property (@(posedge clk) disable iff (!rst_n)
    claim |=> count_r == $past(count_r) + 1'b1)
    else $error("new entry not counted");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ST_OK |-> slot_r == '0 && rval_r == '0)
    else $error("failed result carries slot or value");

  // Hold the result steady while the receiver stalls
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(status_r) &&
      $stable(slot_r) && $stable(rval_r) && $stable(live_r))
    else $error("result changed while stalled");

endmodule
